>>> rtl/srp_pkg.sv
`timescale 1ns / 1ps
package srp_pkg;

  localparam int DATA_W      = 32;
  localparam int HOLD_DEF    = 64;
  localparam int MAX_RESULTS = 64;
  localparam int PADDR_W     = 3;

  typedef logic signed [DATA_W-1:0] q16_t;

  // register indexes, byte address is 4 * index
  typedef enum logic {
    REG_LOWER = 1'b0,
    REG_UPPER = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_PRIME,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic hold;         // write sample to buffer, bump count
    logic emit_direct;  // load output reg from the sample
    logic direct_last;  // end_of_run on the direct beat
    logic prime;        // start drain: read slot 0, index to 0
    logic drain_emit;   // load output reg from buffer read data
    logic clear;        // drain done, empty buffer
  } srp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic full;
    logic empty;
    logic drain_last;
    logic out_free;
  } srp_stat_t;

endpackage

>>> rtl/srp_if.sv
`timescale 1ns / 1ps
interface srp_in_if;
  import srp_pkg::*;
  logic valid;
  logic ready;
  q16_t sample_value;
  logic final_item;

  modport source (output valid, output sample_value, output final_item, input ready);
  modport sink   (input valid, input sample_value, input final_item, output ready);
endinterface

interface srp_out_if;
  import srp_pkg::*;
  logic valid;
  logic ready;
  q16_t result_value;
  logic end_of_run;
  logic overflow_flag;

  modport source (output valid, output result_value, output end_of_run,
                  output overflow_flag, input ready);
  modport sink   (input valid, input result_value, input end_of_run,
                  input overflow_flag, output ready);
endinterface

>>> rtl/srp_ctrl.sv
`timescale 1ns / 1ps
module srp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              final_item,
  input  srp_pkg::srp_stat_t stat,
  output logic              in_ready,
  output srp_pkg::srp_cmd_t cmd
);
  import srp_pkg::*;

  state_t state, state_next;
  logic   accept;
  logic   hold_now;

  assign in_ready = (state == ST_RUN) && stat.out_free;
  assign accept   = in_valid && in_ready;
  assign hold_now = stat.in_range && !stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        // drain only if something is (or is about to be) held
        if (accept && final_item && (hold_now || !stat.empty)) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.out_free && stat.drain_last) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_RUN: begin
        if (accept) begin
          cmd.hold        = hold_now;
          cmd.emit_direct = !hold_now;
          cmd.direct_last = final_item && stat.empty;
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
      end
      ST_DRAIN: begin
        if (stat.out_free) begin
          cmd.drain_emit = 1'b1;
          cmd.clear      = stat.drain_last;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/srp_dp.sv
`timescale 1ns / 1ps
module srp_dp #(
  parameter int HOLD_DEPTH = srp_pkg::HOLD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srp_pkg::srp_cmd_t             cmd,
  output srp_pkg::srp_stat_t            stat,
  input  srp_pkg::q16_t                 sample_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output srp_pkg::q16_t                 result_value,
  output logic                          end_of_run,
  output logic                          overflow_flag,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srp_pkg::PADDR_W-1:0]   paddr,
  input  logic [srp_pkg::DATA_W-1:0]    pwdata,
  output logic [srp_pkg::DATA_W-1:0]    prdata
);
  import srp_pkg::*;

  // capacity is HOLD_DEPTH, capped at MAX_RESULTS - 1 so a final drain fits in one run
  localparam int HOLD_CAP = (HOLD_DEPTH < MAX_RESULTS) ? HOLD_DEPTH : MAX_RESULTS - 1;
  localparam int CNT_W    = $clog2(HOLD_DEPTH + 1);
  localparam int ADDR_W   = $clog2(HOLD_DEPTH);

  q16_t              lower_bound;
  q16_t              upper_bound;
  logic [CNT_W-1:0]  held_count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_inc;
  logic [ADDR_W-1:0] rd_addr;
  q16_t              held_values [HOLD_DEPTH];
  q16_t              rd_data;
  logic              cfg_wr;
  reg_idx_t          cfg_sel;

  // config registers
  assign cfg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= '0;
      upper_bound <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_LOWER: lower_bound <= q16_t'(pwdata);
        REG_UPPER: upper_bound <= q16_t'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_LOWER: prdata = lower_bound;
      REG_UPPER: prdata = upper_bound;
      default:   prdata = '0;
    endcase
  end

  // counters
  assign idx_inc = idx + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      idx        <= '0;
    end else begin
      if (cmd.clear) begin
        held_count <= '0;
      end else if (cmd.hold) begin
        held_count <= held_count + CNT_W'(1);
      end
      if (cmd.prime) begin
        idx <= '0;
      end else if (cmd.drain_emit) begin
        idx <= idx_inc;
      end
    end
  end

  // buffer: read data always tracks the slot at idx during a drain
  always_comb begin
    if (cmd.prime) begin
      rd_addr = '0;
    end else if (cmd.drain_emit) begin
      rd_addr = idx_inc[ADDR_W-1:0];
    end else begin
      rd_addr = idx[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold) begin
      held_values[held_count[ADDR_W-1:0]] <= sample_value;
    end
    rd_data <= held_values[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_direct || cmd.drain_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_direct) begin
      result_value  <= sample_value;
      end_of_run    <= cmd.direct_last;
      overflow_flag <= stat.in_range;
    end else if (cmd.drain_emit) begin
      result_value  <= rd_data;
      end_of_run    <= stat.drain_last;
      overflow_flag <= 1'b0;
    end
  end

  assign stat.in_range   = !(sample_value < lower_bound || sample_value > upper_bound);
  assign stat.full       = (held_count == CNT_W'(HOLD_CAP));
  assign stat.empty      = (held_count == '0);
  assign stat.drain_last = (idx_inc == held_count);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

>>> rtl/stable_range_partition.sv
`timescale 1ns / 1ps
// Stable range partition of signed Q16.16 samples.
// samples: input beats (sample_value, final_item), taken when valid && ready.
// results: output beats (result_value, end_of_run, overflow_flag).
// A sample outside [lower_bound, upper_bound] leaves as the next result beat,
// in the cycle after it is taken (output register). An in-range sample is kept
// in a buffer RAM; with the buffer full it leaves at once with overflow_flag.
// A final_item beat with samples held drains the buffer in arrival order;
// the very last beat of the run carries end_of_run.
// Throughput: one sample per cycle while streaming and not stalled. A final
// beat with held samples is followed by a RAM prime state, then a drain of one
// output beat at a time (single RAM read port) before the next sample is taken.
// Config: APB, lower_bound at 0x0, upper_bound at 0x4, pready tied high.
// Write bounds only while idle.
// Reset (rst, sync, active high): bounds to 0, buffer empty, no result beat
// pending. The RAM contents are not cleared; only written slots reach the output.
// Receiver stall: the output register holds its beat; input ready drops
// until the register frees, so nothing is lost or repeated.
module stable_range_partition #(
  parameter int HOLD_DEPTH = srp_pkg::HOLD_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  srp_in_if.sink                      samples,
  srp_out_if.source                   results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srp_pkg::PADDR_W-1:0] paddr,
  input  logic [srp_pkg::DATA_W-1:0]  pwdata,
  output logic [srp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import srp_pkg::*;

  srp_cmd_t  cmd;
  srp_stat_t stat;

  assign pready = 1'b1;

  // sequencer: run / prime / drain
  srp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (samples.valid),
    .final_item (samples.final_item),
    .stat       (stat),
    .in_ready   (samples.ready),
    .cmd        (cmd)
  );

  // bounds, compare, buffer RAM, counters, output register
  srp_dp #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .sample_value  (samples.sample_value),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .result_value  (results.result_value),
    .end_of_run    (results.end_of_run),
    .overflow_flag (results.overflow_flag),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
  );

endmodule

>>> rtl/srp_checker.sv
`timescale 1ns / 1ps
module srp_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input srp_pkg::q16_t       result_value,
  input logic                end_of_run,
  input logic                overflow_flag,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_final
);
  import srp_pkg::*;

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat pending after reset");

  // stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value)
      && $stable(end_of_run) && $stable(overflow_flag))
    else $error("stalled result beat changed");

  // an overflow bypass implies held data, so it never ends the run
  a_ovf_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(end_of_run && overflow_flag))
    else $error("overflow beat marked end_of_run");

  // a taken final beat is followed by a result beat or a drain
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_final |=> !in_ready || out_valid
      || $past(out_valid && !out_ready))
    else $error("final beat taken without a result or drain");

endmodule

bind stable_range_partition srp_checker u_srp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .result_value  (results.result_value),
  .end_of_run    (results.end_of_run),
  .overflow_flag (results.overflow_flag),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .in_final      (samples.final_item)
);
